// ===== design/pcc_pkg.sv =====
`default_nettype none
package pcc_pkg;

    // commands
    localparam logic CMD_P2C = 1'b0;
    localparam logic CMD_C2P = 1'b1;

    // result status
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADRHO = 2'd1;
    localparam logic [1:0] ST_SAT    = 2'd2;

    // configuration port
    localparam int CFG_IDX_W = 2;
    localparam int GAMMA_W   = 31;
    localparam logic [CFG_IDX_W-1:0] CFG_MHD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GM1  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IGM1 = 2'd2;

    localparam logic [GAMMA_W-1:0] GM1_RST  = 31'd43691;
    localparam logic [GAMMA_W-1:0] IGM1_RST = 31'd98304;

endpackage
`default_nettype wire

// ===== design/pcc_divider.sv =====
`default_nettype none
// Pipelined restoring divider: (num * 2^F) / den, one quotient bit per stage,
// rounded half away from zero and saturated to the signed word.
module pcc_divider #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                i_clk,
    input  logic signed [W-1:0] i_num,
    input  logic        [W-1:0] i_den,
    output logic signed [W-1:0] o_quo,
    output logic                o_sat
);
    localparam int Q  = W + F;
    localparam int RW = W + 1;

    logic [RW-1:0] r_rem [Q];
    logic [Q-1:0]  r_num [Q];
    logic [Q-1:0]  r_q   [Q];
    logic [W-1:0]  r_den [Q];
    logic          r_neg [Q];

    logic [W-1:0] mag;
    assign mag = i_num[W-1] ? W'(-i_num) : W'(i_num);

    for (genvar k = 0; k < Q; k++) begin : g_stage
        logic [RW-1:0] rem_i;
        logic [Q-1:0]  num_i;
        logic [Q-1:0]  q_i;
        logic [W-1:0]  den_i;
        logic          neg_i;
        logic [RW-1:0] tr;
        logic          ge;

        if (k == 0) begin : g_first
            assign rem_i = '0;
            assign num_i = {mag, {F{1'b0}}};
            assign q_i   = '0;
            assign den_i = i_den;
            assign neg_i = i_num[W-1];
        end else begin : g_next
            assign rem_i = r_rem[k-1];
            assign num_i = r_num[k-1];
            assign q_i   = r_q[k-1];
            assign den_i = r_den[k-1];
            assign neg_i = r_neg[k-1];
        end

        assign tr = {rem_i[RW-2:0], num_i[Q-1]};
        assign ge = tr >= {1'b0, den_i};

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? (tr - {1'b0, den_i}) : tr;
            r_num[k] <= num_i << 1;
            r_q[k]   <= {q_i[Q-2:0], ge};
            r_den[k] <= den_i;
            r_neg[k] <= neg_i;
        end
    end

    logic          rnd;
    logic [Q:0]    q1;
    logic [Q:0]    lim;

    always_comb begin
        rnd = {r_rem[Q-1], 1'b0} >= {2'b00, r_den[Q-1]};
        q1  = {1'b0, r_q[Q-1]} + (Q+1)'(rnd);
        lim = r_neg[Q-1] ? ((Q+1)'(1) << (W-1)) : (((Q+1)'(1) << (W-1)) - (Q+1)'(1));
        o_sat = q1 > lim;
        if (o_sat) begin
            o_quo = r_neg[Q-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        end else begin
            o_quo = r_neg[Q-1] ? W'(-q1[W-1:0]) : q1[W-1:0];
        end
    end

endmodule
`default_nettype wire

// ===== design/primitive_conserved_convert_unit.sv =====
`default_nettype none
// Pipeline from accept to o_strobe (Q16.16 by default): capture, products, sums of squares,
//   bit-per-stage dividers for the momentum and energy quotients, energy terms, output.
// Throughput: one item per cycle; start is taken whenever busy is low.
// The receiver cannot stall: each result shows for one cycle with o_strobe.
// Reset (synchronous, active low) clears all valid bits and loads the register
//   defaults; busy is high while reset is held.
module primitive_conserved_convert_unit #(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [pcc_pkg::GAMMA_W-1:0]   i_cfg_wdata,
    input  logic                          i_cmd,
    input  logic signed [WORD_BITS-1:0]   i_density_in,
    input  logic signed [WORD_BITS-1:0]   i_flow_x_in,
    input  logic signed [WORD_BITS-1:0]   i_flow_y_in,
    input  logic signed [WORD_BITS-1:0]   i_flow_z_in,
    input  logic signed [WORD_BITS-1:0]   i_field_x_in,
    input  logic signed [WORD_BITS-1:0]   i_field_y_in,
    input  logic signed [WORD_BITS-1:0]   i_field_z_in,
    input  logic signed [WORD_BITS-1:0]   i_thermo_in,
    output logic                          o_strobe,
    output logic signed [WORD_BITS-1:0]   o_density_out,
    output logic signed [WORD_BITS-1:0]   o_flow_x_out,
    output logic signed [WORD_BITS-1:0]   o_flow_y_out,
    output logic signed [WORD_BITS-1:0]   o_flow_z_out,
    output logic signed [WORD_BITS-1:0]   o_field_x_out,
    output logic signed [WORD_BITS-1:0]   o_field_y_out,
    output logic signed [WORD_BITS-1:0]   o_field_z_out,
    output logic signed [WORD_BITS-1:0]   o_thermo_out,
    output logic [1:0]                    o_status
);
    import pcc_pkg::*;

    localparam int W   = WORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int Q   = W + F;            // divider depth
    localparam int MW  = (W > 32) ? W : 32; // multiplier operand width
    localparam int LAT = Q + 6;

    localparam logic [W-1:0] WMAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] WMINV = {1'b1, {(W-1){1'b0}}};

    typedef struct packed {
        logic         sat;
        logic [W-1:0] v;
    } t_res;

    // ---------------- saturating fixed-point helpers ----------------
    function automatic t_res f_clip(input logic signed [W+1:0] s);
        t_res o;
        if (s > $signed({3'b000, {(W-1){1'b1}}})) begin
            o.sat = 1'b1;
            o.v   = WMAXV;
        end else if (s < $signed({3'b111, {(W-1){1'b0}}})) begin
            o.sat = 1'b1;
            o.v   = WMINV;
        end else begin
            o.sat = 1'b0;
            o.v   = s[W-1:0];
        end
        return o;
    endfunction

    function automatic t_res f_qadd(input logic [W-1:0] a, input logic [W-1:0] b);
        logic signed [W+1:0] s;
        s = $signed({a[W-1], a[W-1], a}) + $signed({b[W-1], b[W-1], b});
        return f_clip(s);
    endfunction

    function automatic t_res f_qsub(input logic [W-1:0] a, input logic [W-1:0] b);
        logic signed [W+1:0] s;
        s = $signed({a[W-1], a[W-1], a}) - $signed({b[W-1], b[W-1], b});
        return f_clip(s);
    endfunction

    // product scaled by 2^-F, rounded half away from zero, saturated
    function automatic t_res f_qmul(input logic [MW-1:0] a, input logic [MW-1:0] b);
        logic            neg;
        logic [MW-1:0]   ma;
        logic [MW-1:0]   mb;
        logic [2*MW-1:0] p;
        logic [2*MW-1:0] r;
        logic [2*MW-1:0] lim;
        t_res            o;
        neg = a[MW-1] ^ b[MW-1];
        ma  = a[MW-1] ? (~a + MW'(1)) : a;
        mb  = b[MW-1] ? (~b + MW'(1)) : b;
        p   = ma * mb;
        r   = (p + ((2*MW)'(1) << (F-1))) >> F;
        lim = neg ? ((2*MW)'(1) << (W-1)) : (((2*MW)'(1) << (W-1)) - (2*MW)'(1));
        o.sat = r > lim;
        if (o.sat) begin
            o.v = neg ? WMINV : WMAXV;
        end else begin
            o.v = neg ? W'(-r[W-1:0]) : r[W-1:0];
        end
        return o;
    endfunction

    function automatic logic [MW-1:0] f_wx(input logic signed [W-1:0] x);
        return MW'(x);
    endfunction

    function automatic logic [MW-1:0] f_gx(input logic [GAMMA_W-1:0] g);
        return MW'({1'b0, g});
    endfunction

    // times 0.5 in fixed point: magnitude (m + 1) >> 1, never saturates
    function automatic logic [W-1:0] f_half(input logic [W-1:0] k);
        logic [W-1:0] mag;
        logic [W:0]   h;
        mag = k[W-1] ? W'(-k) : k;
        h   = ({1'b0, mag} + (W+1)'(1)) >> 1;
        return k[W-1] ? W'(-h[W-1:0]) : h[W-1:0];
    endfunction

    // ---------------- configuration ----------------
    logic                 r_mhd;
    logic [GAMMA_W-1:0]   r_gm1;
    logic [GAMMA_W-1:0]   r_igm1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mhd  <= 1'b1;
            r_gm1  <= GM1_RST;
            r_igm1 <= IGM1_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MHD:  r_mhd  <= i_cfg_wdata[0];
                CFG_GM1:  r_gm1  <= i_cfg_wdata;
                CFG_IGM1: r_igm1 <= i_cfg_wdata;
                default:  ;
            endcase
        end
    end

    // no backpressure: only reset holds off new items
    assign busy = ~i_rst_n;

    logic accept;
    assign accept = start && !busy;

    // ---------------- stage 0: capture ----------------
    logic                r0_v;
    logic                r0_cmd;
    logic [W-1:0]        r0_rho;
    logic [W-1:0]        r0_th;
    logic [2:0][W-1:0]   r0_f;
    logic [2:0][W-1:0]   r0_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else begin
            r0_v <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r0_cmd  <= i_cmd;
        r0_rho  <= i_density_in;
        r0_th   <= i_thermo_in;
        r0_f[0] <= i_flow_x_in;
        r0_f[1] <= i_flow_y_in;
        r0_f[2] <= i_flow_z_in;
        // hydrodynamic mode drops the field entirely
        r0_b[0] <= r_mhd ? i_field_x_in : '0;
        r0_b[1] <= r_mhd ? i_field_y_in : '0;
        r0_b[2] <= r_mhd ? i_field_z_in : '0;
    end

    // ---------------- stage 1: products ----------------
    logic                r1_v;
    logic                r1_cmd;
    logic                r1_sat;
    logic [W-1:0]        r1_rho;
    logic [W-1:0]        r1_th;
    logic [W-1:0]        r1_thi;
    logic [2:0][W-1:0]   r1_f;
    logic [2:0][W-1:0]   r1_b;
    logic [2:0][W-1:0]   r1_mf;
    logic [2:0][W-1:0]   r1_sqf;
    logic [2:0][W-1:0]   r1_sqb;

    t_res                s1_mf  [3];
    t_res                s1_sqf [3];
    t_res                s1_sqb [3];
    t_res                s1_thi;
    logic                s1_sat;

    always_comb begin
        s1_sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            s1_mf[i]  = f_qmul(f_wx(r0_rho), f_wx(r0_f[i]));
            s1_sqf[i] = f_qmul(f_wx(r0_f[i]), f_wx(r0_f[i]));
            s1_sqb[i] = f_qmul(f_wx(r0_b[i]), f_wx(r0_b[i]));
            s1_sat = s1_sat | s1_sqf[i].sat | s1_sqb[i].sat
                   | ((r0_cmd == CMD_P2C) & s1_mf[i].sat);
        end
        s1_thi = f_qmul(f_wx(r0_th), f_gx(r_igm1));
        s1_sat = s1_sat | ((r0_cmd == CMD_P2C) & s1_thi.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else begin
            r1_v <= r0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_cmd <= r0_cmd;
        r1_sat <= s1_sat;
        r1_rho <= r0_rho;
        r1_th  <= r0_th;
        r1_thi <= s1_thi.v;
        r1_f   <= r0_f;
        r1_b   <= r0_b;
        for (int i = 0; i < 3; i++) begin
            r1_mf[i]  <= s1_mf[i].v;
            r1_sqf[i] <= s1_sqf[i].v;
            r1_sqb[i] <= s1_sqb[i].v;
        end
    end

    // ---------------- stage 2: sums of squares ----------------
    logic                r2_v;
    logic                r2_cmd;
    logic                r2_sat;
    logic [W-1:0]        r2_rho;
    logic [W-1:0]        r2_th;
    logic [W-1:0]        r2_thi;
    logic [W-1:0]        r2_vv;
    logic [W-1:0]        r2_bb;
    logic [2:0][W-1:0]   r2_f;
    logic [2:0][W-1:0]   r2_b;
    logic [2:0][W-1:0]   r2_mf;

    t_res s2_f01, s2_vv, s2_b01, s2_bb;

    always_comb begin
        s2_f01 = f_qadd(r1_sqf[0], r1_sqf[1]);
        s2_vv  = f_qadd(s2_f01.v, r1_sqf[2]);
        s2_b01 = f_qadd(r1_sqb[0], r1_sqb[1]);
        s2_bb  = f_qadd(s2_b01.v, r1_sqb[2]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else begin
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_cmd <= r1_cmd;
        r2_sat <= r1_sat | s2_f01.sat | s2_vv.sat | s2_b01.sat | s2_bb.sat;
        r2_rho <= r1_rho;
        r2_th  <= r1_th;
        r2_thi <= r1_thi;
        r2_vv  <= s2_vv.v;
        r2_bb  <= s2_bb.v;
        r2_f   <= r1_f;
        r2_b   <= r1_b;
        r2_mf  <= r1_mf;
    end

    // ---------------- dividers (conserved to primitive) ----------------
    logic [W-1:0] dq_f [3];
    logic         dq_fs [3];
    logic [W-1:0] dq_k;
    logic         dq_ks;

    for (genvar i = 0; i < 3; i++) begin : g_fdiv
        pcc_divider #(.W(W), .F(F)) u_fdiv (
            .i_clk (i_clk),
            .i_num (r2_f[i]),
            .i_den (r2_rho),
            .o_quo (dq_f[i]),
            .o_sat (dq_fs[i])
        );
    end

    pcc_divider #(.W(W), .F(F)) u_kdiv (
        .i_clk (i_clk),
        .i_num (r2_vv),
        .i_den (r2_rho),
        .o_quo (dq_k),
        .o_sat (dq_ks)
    );

    // ---------------- side data, aligned with the dividers ----------------
    typedef struct packed {
        logic              cmd;
        logic              bad;
        logic              sat;
        logic [W-1:0]      rho;
        logic [W-1:0]      th;
        logic [W-1:0]      thi;
        logic [W-1:0]      bb;
        logic [W-1:0]      kin0;
        logic [2:0][W-1:0] mf;
        logic [2:0][W-1:0] b;
    } t_side;

    t_side        r_dly [Q];
    logic [Q-1:0] r_dv;
    t_side        s3_side;
    t_res         s3_kin;

    always_comb begin
        s3_kin        = f_qmul(f_wx(r2_rho), f_wx(r2_vv));
        s3_side.cmd   = r2_cmd;
        s3_side.bad   = (r2_cmd == CMD_C2P) && (r2_rho[W-1] || (r2_rho == '0));
        s3_side.sat   = r2_sat | ((r2_cmd == CMD_P2C) & s3_kin.sat);
        s3_side.rho   = r2_rho;
        s3_side.th    = r2_th;
        s3_side.thi   = r2_thi;
        s3_side.bb    = r2_bb;
        s3_side.kin0  = s3_kin.v;
        s3_side.mf    = r2_mf;
        s3_side.b     = r2_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= '0;
        end else begin
            r_dv <= {r_dv[Q-2:0], r2_v};
        end
    end

    always_ff @(posedge i_clk) begin
        r_dly[0] <= s3_side;
        for (int k = 1; k < Q; k++) begin
            r_dly[k] <= r_dly[k-1];
        end
    end

    // ---------------- stage 4: pick kinetic term, add field energy ----------------
    t_side             s4_in;
    logic [W-1:0]      s4_kin;
    t_res              s4_kb;
    logic              s4_sat;

    logic              r4_v;
    logic              r4_cmd;
    logic              r4_bad;
    logic              r4_sat;
    logic [W-1:0]      r4_rho;
    logic [W-1:0]      r4_th;
    logic [W-1:0]      r4_thi;
    logic [W-1:0]      r4_kin;
    logic [2:0][W-1:0] r4_fl;
    logic [2:0][W-1:0] r4_b;

    always_comb begin
        s4_in  = r_dly[Q-1];
        s4_kin = (s4_in.cmd == CMD_C2P) ? dq_k : s4_in.kin0;
        s4_kb  = f_qadd(s4_kin, s4_in.bb);
        s4_sat = s4_in.sat | (r_mhd & s4_kb.sat);
        if (s4_in.cmd == CMD_C2P) begin
            s4_sat = s4_sat | dq_ks | dq_fs[0] | dq_fs[1] | dq_fs[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else begin
            r4_v <= r_dv[Q-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r4_cmd <= s4_in.cmd;
        r4_bad <= s4_in.bad;
        r4_sat <= s4_sat;
        r4_rho <= s4_in.rho;
        r4_th  <= s4_in.th;
        r4_thi <= s4_in.thi;
        r4_kin <= r_mhd ? s4_kb.v : s4_kin;
        r4_b   <= s4_in.b;
        for (int i = 0; i < 3; i++) begin
            r4_fl[i] <= (s4_in.cmd == CMD_C2P) ? dq_f[i] : s4_in.mf[i];
        end
    end

    // ---------------- stage 5: halve, combine with thermal term ----------------
    logic [W-1:0]      s5_h;
    t_res              s5_e;
    t_res              s5_d;

    logic              r5_v;
    logic              r5_cmd;
    logic              r5_bad;
    logic              r5_sat;
    logic [W-1:0]      r5_rho;
    logic [W-1:0]      r5_t;
    logic [2:0][W-1:0] r5_fl;
    logic [2:0][W-1:0] r5_b;

    always_comb begin
        s5_h = f_half(r4_kin);
        s5_e = f_qadd(s5_h, r4_thi);  // total energy
        s5_d = f_qsub(r4_th, s5_h);   // internal energy
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else begin
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r5_cmd <= r4_cmd;
        r5_bad <= r4_bad;
        r5_sat <= r4_sat | ((r4_cmd == CMD_C2P) ? s5_d.sat : s5_e.sat);
        r5_rho <= r4_rho;
        r5_t   <= (r4_cmd == CMD_C2P) ? s5_d.v : s5_e.v;
        r5_fl  <= r4_fl;
        r5_b   <= r4_b;
    end

    // ---------------- stage 6: pressure product, output register ----------------
    t_res s6_p;
    logic s6_sat;

    always_comb begin
        s6_p   = f_qmul(f_gx(r_gm1), f_wx(r5_t));
        s6_sat = r5_sat | ((r5_cmd == CMD_C2P) & s6_p.sat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_strobe <= 1'b0;
        end else begin
            o_strobe <= r5_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r5_bad) begin
            // nonpositive density: everything zero, status only
            o_density_out <= '0;
            o_flow_x_out  <= '0;
            o_flow_y_out  <= '0;
            o_flow_z_out  <= '0;
            o_field_x_out <= '0;
            o_field_y_out <= '0;
            o_field_z_out <= '0;
            o_thermo_out  <= '0;
            o_status      <= ST_BADRHO;
        end else begin
            o_density_out <= r5_rho;
            o_flow_x_out  <= r5_fl[0];
            o_flow_y_out  <= r5_fl[1];
            o_flow_z_out  <= r5_fl[2];
            o_field_x_out <= r5_b[0];
            o_field_y_out <= r5_b[1];
            o_field_z_out <= r5_b[2];
            o_thermo_out  <= (r5_cmd == CMD_C2P) ? s6_p.v : r5_t;
            o_status      <= s6_sat ? ST_SAT : ST_OK;
        end
    end

    // ---------------- assertions ----------------
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##LAT o_strobe)
        else $error("accepted item produced no result strobe");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, LAT))
        else $error("result strobe without an accepted item");

    a_badrho_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status == ST_BADRHO) |->
            (o_density_out == '0 && o_thermo_out == '0 && o_flow_x_out == '0))
        else $error("nonpositive density result not cleared");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_status == ST_OK || o_status == ST_BADRHO || o_status == ST_SAT))
        else $error("undefined status code");

endmodule
`default_nettype wire

// ===== verif/primitive_conserved_convert_unit_tb.sv =====
`timescale 1ns / 1ps

module primitive_conserved_convert_unit_tb;
    import pcc_pkg::*;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    // accept to strobe, the same span as LAT in the block
    localparam int PIPE_LATENCY = WORD_BITS + FRAC_BITS + 6;
    localparam int CYCLE_LIMIT = 200000;

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef struct {
        logic  cmd;
        word_t rho;
        word_t flow [3];
        word_t field [3];
        word_t thermo;
    } cell_in_t;

    typedef struct {
        word_t       rho;
        word_t       flow [3];
        word_t       field [3];
        word_t       thermo;
        logic [1:0]  status;
    } cell_out_t;

    // Predicts each cell conversion and keeps the results still owed by the pipeline.
    class conversion_scoreboard;
        logic                mhd_on;
        logic [GAMMA_W-1:0]  gm1;
        logic [GAMMA_W-1:0]  inv_gm1;
        cell_out_t           owed_cells [$];
        int                  mismatches;
        int                  checked;
        int                  cmd_seen [2];
        int                  status_seen [4];

        function new();
            mhd_on      = 1'b1;
            gm1         = GM1_RST;
            inv_gm1     = IGM1_RST;
            mismatches  = 0;
            checked     = 0;
            cmd_seen    = '{0, 0};
            status_seen = '{0, 0, 0, 0};
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [GAMMA_W-1:0] data);
            case (idx)
                CFG_MHD:  mhd_on  = data[0];
                CFG_GM1:  gm1     = data;
                CFG_IGM1: inv_gm1 = data;
                default: ;
            endcase
        endfunction

        function word_t clamp(logic signed [127:0] v, inout bit sat);
            if (v > 128'sh7fff_ffff) begin
                sat = 1;
                return 32'sh7fff_ffff;
            end
            if (v < -128'sh8000_0000) begin
                sat = 1;
                return 32'sh8000_0000;
            end
            return v[WORD_BITS-1:0];
        endfunction

        // fixed-point product, rounded half away from zero
        function word_t fx_mul(logic signed [127:0] a, logic signed [127:0] b, inout bit sat);
            logic signed [127:0] p;
            logic signed [127:0] m;
            p = a * b;
            m = (p < 0) ? -p : p;
            m = (m + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            return clamp((p < 0) ? -m : m, sat);
        endfunction

        function word_t fx_add(logic signed [127:0] a, logic signed [127:0] b, inout bit sat);
            return clamp(a + b, sat);
        endfunction

        // den is always positive here
        function word_t fx_div(logic signed [127:0] num, logic signed [127:0] den, inout bit sat);
            logic [127:0] n;
            logic [127:0] q;
            logic [127:0] r;
            n = ((num < 0) ? -num : num) << FRAC_BITS;
            q = n / den;
            r = n % den;
            if (2 * r >= den) q = q + 1;
            return clamp((num < 0) ? -$signed(q) : $signed(q), sat);
        endfunction

        function word_t norm_sq(word_t v [3], inout bit sat);
            word_t s;
            s = fx_add(fx_mul(v[0], v[0], sat), fx_mul(v[1], v[1], sat), sat);
            return fx_add(s, fx_mul(v[2], v[2], sat), sat);
        endfunction

        function void note_cell(cell_in_t c);
            cell_out_t e;
            bit        sat;
            word_t     kin;
            word_t     b [3];
            sat = 0;
            cmd_seen[c.cmd]++;
            for (int i = 0; i < 3; i++) b[i] = mhd_on ? c.field[i] : '0;
            e.rho = '0;
            e.thermo = '0;
            for (int i = 0; i < 3; i++) begin
                e.flow[i]  = '0;
                e.field[i] = '0;
            end
            if (c.cmd == CMD_C2P && c.rho <= 0) begin
                e.status = ST_BADRHO;
                owed_cells.push_back(e);
                return;
            end
            e.rho = c.rho;
            if (c.cmd == CMD_P2C) begin
                for (int i = 0; i < 3; i++) e.flow[i] = fx_mul(c.rho, c.flow[i], sat);
                kin = fx_mul(c.rho, norm_sq(c.flow, sat), sat);
                if (mhd_on) kin = fx_add(kin, norm_sq(b, sat), sat);
                kin = fx_mul(kin, 1 << (FRAC_BITS - 1), sat);
                e.thermo = fx_add(kin, fx_mul(c.thermo, {1'b0, inv_gm1}, sat), sat);
            end else begin
                for (int i = 0; i < 3; i++) e.flow[i] = fx_div(c.flow[i], c.rho, sat);
                kin = fx_div(norm_sq(c.flow, sat), c.rho, sat);
                if (mhd_on) kin = fx_add(kin, norm_sq(b, sat), sat);
                kin = fx_mul(kin, 1 << (FRAC_BITS - 1), sat);
                // negation of the kinetic term is exact, only the sum saturates
                e.thermo = fx_mul({1'b0, gm1}, fx_add(c.thermo, -kin, sat), sat);
            end
            for (int i = 0; i < 3; i++) e.field[i] = b[i];
            e.status = sat ? ST_SAT : ST_OK;
            owed_cells.push_back(e);
        endfunction

        function void report(string what, logic [WORD_BITS-1:0] exp_v,
                             logic [WORD_BITS-1:0] act_v);
            mismatches++;
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, exp_v, act_v);
        endfunction

        function void check_cell(cell_out_t a);
            cell_out_t e;
            if (owed_cells.size() == 0) begin
                mismatches++;
                $display("%0t ns: result strobe with no item outstanding", $time);
                return;
            end
            e = owed_cells.pop_front();
            checked++;
            status_seen[e.status]++;
            if (a.rho !== e.rho) report("density", e.rho, a.rho);
            for (int i = 0; i < 3; i++) begin
                if (a.flow[i] !== e.flow[i]) report($sformatf("flow[%0d]", i), e.flow[i], a.flow[i]);
                if (a.field[i] !== e.field[i])
                    report($sformatf("field[%0d]", i), e.field[i], a.field[i]);
            end
            if (a.thermo !== e.thermo) report("thermo", e.thermo, a.thermo);
            if (a.status !== e.status) report("status", e.status, a.status);
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic               i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [GAMMA_W-1:0] i_cfg_wdata;
    logic               i_cmd;
    word_t              i_density_in, i_flow_x_in, i_flow_y_in, i_flow_z_in;
    word_t              i_field_x_in, i_field_y_in, i_field_z_in, i_thermo_in;
    logic               o_strobe;
    word_t              o_density_out, o_flow_x_out, o_flow_y_out, o_flow_z_out;
    word_t              o_field_x_out, o_field_y_out, o_field_z_out, o_thermo_out;
    logic [1:0]         o_status;

    conversion_scoreboard sb = new();
    int accepted_items = 0;
    int cycle_count = 0;
    int sender_idle_pct = 0;

    primitive_conserved_convert_unit #(
        .WORD_BITS(WORD_BITS),
        .FRAC_BITS(FRAC_BITS)
    ) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_wdata(i_cfg_wdata),
        .i_cmd(i_cmd), .i_density_in(i_density_in),
        .i_flow_x_in(i_flow_x_in), .i_flow_y_in(i_flow_y_in), .i_flow_z_in(i_flow_z_in),
        .i_field_x_in(i_field_x_in), .i_field_y_in(i_field_y_in),
        .i_field_z_in(i_field_z_in), .i_thermo_in(i_thermo_in),
        .o_strobe(o_strobe), .o_density_out(o_density_out),
        .o_flow_x_out(o_flow_x_out), .o_flow_y_out(o_flow_y_out),
        .o_flow_z_out(o_flow_z_out), .o_field_x_out(o_field_x_out),
        .o_field_y_out(o_field_y_out), .o_field_z_out(o_field_z_out),
        .o_thermo_out(o_thermo_out), .o_status(o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Monitor: inputs move on the falling edge, so everything here is stable at the
    // rising edge. Register writes, accepted items and results are all seen here.
    always @(posedge i_clk) begin
        cell_in_t  c;
        cell_out_t r;
        if (i_rst_n && i_cfg_we) sb.write_reg(i_cfg_idx, i_cfg_wdata);
        if (i_rst_n && start && !busy) begin
            c.cmd      = i_cmd;
            c.rho      = i_density_in;
            c.flow     = '{i_flow_x_in, i_flow_y_in, i_flow_z_in};
            c.field    = '{i_field_x_in, i_field_y_in, i_field_z_in};
            c.thermo   = i_thermo_in;
            sb.note_cell(c);
            accepted_items++;
        end
        if (i_rst_n && o_strobe) begin
            r.rho    = o_density_out;
            r.flow   = '{o_flow_x_out, o_flow_y_out, o_flow_z_out};
            r.field  = '{o_field_x_out, o_field_y_out, o_field_z_out};
            r.thermo = o_thermo_out;
            r.status = o_status;
            sb.check_cell(r);
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.owed_cells.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Register write, one cycle of write enable; block must be idle.
    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [GAMMA_W-1:0] data);
        i_cfg_we    = 1'b1;
        i_cfg_idx   = idx;
        i_cfg_wdata = data;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
    endtask

    // Present one item and hold it until the monitor has seen it accepted.
    // start stays high on return so back-to-back items need no gap.
    task automatic send_cell(cell_in_t c);
        int prev;
        while (sender_idle_pct > 0 && $urandom_range(99, 0) < sender_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        i_cmd        = c.cmd;
        i_density_in = c.rho;
        i_flow_x_in  = c.flow[0];
        i_flow_y_in  = c.flow[1];
        i_flow_z_in  = c.flow[2];
        i_field_x_in = c.field[0];
        i_field_y_in = c.field[1];
        i_field_z_in = c.field[2];
        i_thermo_in  = c.thermo;
        start        = 1'b1;
        prev = accepted_items;
        do @(negedge i_clk); while (accepted_items == prev);
    endtask

    // Drop start, let every owed result come back, then allow the pipeline to empty.
    task automatic drain();
        start = 1'b0;
        while (sb.owed_cells.size() != 0) @(negedge i_clk);
        repeat (PIPE_LATENCY + 4) @(negedge i_clk);
    endtask

    // Mostly physical magnitudes, with full-range words and the extremes mixed in.
    function automatic word_t rand_word();
        case ($urandom_range(9, 0))
            0, 1, 2, 3: return $signed(32'($urandom_range(1 << 21, 0))) - (1 << 20);
            4, 5, 6:    return $urandom;
            7:          return 32'sh7fff_ffff;
            8:          return 32'sh8000_0000;
            default:    return $signed(32'($urandom_range(2, 0))) - 1;
        endcase
    endfunction

    function automatic cell_in_t rand_cell();
        cell_in_t c;
        c.cmd = 1'($urandom_range(1, 0));
        // well-formed density most of the time so conversions get past the density check
        if ($urandom_range(9, 0) < 8) c.rho = $urandom_range(1 << 22, 1);
        else c.rho = rand_word();
        for (int i = 0; i < 3; i++) begin
            c.flow[i]  = rand_word();
            c.field[i] = rand_word();
        end
        c.thermo = rand_word();
        return c;
    endfunction

    function automatic cell_in_t make_cell(logic cmd, word_t rho, word_t v, word_t b, word_t t);
        cell_in_t c;
        c.cmd    = cmd;
        c.rho    = rho;
        c.flow   = '{v, -v, v};
        c.field  = '{b, b, -b};
        c.thermo = t;
        return c;
    endfunction

    task automatic random_phase(int count, int idle_pct);
        sender_idle_pct = idle_pct;
        for (int n = 0; n < count; n++) begin
            // in the phase with 51 percent idling, one hold-off mid phase: wait until every owed result is back
            if (n == count / 2 && idle_pct == 51) begin
                start = 1'b0;
                while (sb.owed_cells.size() != 0) @(negedge i_clk);
            end
            send_cell(rand_cell());
        end
        sender_idle_pct = 0;
    endtask

    localparam word_t ONE  = 32'sh0001_0000;
    localparam word_t WMAX = 32'sh7fff_ffff;
    localparam word_t WMIN = 32'sh8000_0000;

    initial begin
        start = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_MHD;
        i_cfg_wdata = '0;
        i_cmd = CMD_P2C;
        {i_density_in, i_flow_x_in, i_flow_y_in, i_flow_z_in} = '0;
        {i_field_x_in, i_field_y_in, i_field_z_in, i_thermo_in} = '0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: reset settings, MHD on.
        send_cell(make_cell(CMD_P2C, ONE, ONE, ONE, ONE));
        send_cell(make_cell(CMD_C2P, ONE, ONE, ONE, 4 * ONE));
        send_cell(make_cell(CMD_P2C, '0, '0, '0, '0));
        send_cell(make_cell(CMD_P2C, WMAX, WMAX, WMAX, WMAX));
        send_cell(make_cell(CMD_P2C, WMIN, WMIN, WMIN, WMIN));
        send_cell(make_cell(CMD_C2P, WMAX, WMAX, WMAX, WMAX));
        send_cell(make_cell(CMD_C2P, WMAX, WMIN, WMIN, WMIN));
        // density at or below zero in the inverse direction
        send_cell(make_cell(CMD_C2P, '0, ONE, ONE, ONE));
        send_cell(make_cell(CMD_C2P, -1, ONE, ONE, ONE));
        send_cell(make_cell(CMD_C2P, WMIN, WMAX, WMAX, WMAX));
        // smallest density: quotients saturate for a unit flow, not for the smallest flow
        send_cell(make_cell(CMD_C2P, 32'sd1, ONE, '0, '0));
        send_cell(make_cell(CMD_C2P, 32'sd1, -32'sd1, '0, '0));
        // rounding at the half step
        send_cell(make_cell(CMD_P2C, 32'sd1, 32'sh0000_8000, '0, 32'sd1));
        send_cell(make_cell(CMD_P2C, -32'sd1, 32'sh0000_8000, 32'sd1, -32'sd1));
        send_cell(make_cell(CMD_C2P, 3 * ONE, 32'sd1, 32'sd1, WMIN));
        drain();

        // Hydrodynamic mode, gamma registers at their extremes; a zero gamma too.
        write_cfg(CFG_MHD, '0);
        write_cfg(CFG_GM1, '0);
        write_cfg(CFG_IGM1, '0);
        send_cell(make_cell(CMD_P2C, 2 * ONE, ONE, 5 * ONE, 7 * ONE));
        send_cell(make_cell(CMD_C2P, 2 * ONE, ONE, 5 * ONE, 7 * ONE));
        drain();
        write_cfg(CFG_GM1, 31'h7fff_ffff);
        write_cfg(CFG_IGM1, 31'd1);
        send_cell(make_cell(CMD_P2C, 2 * ONE, ONE, 5 * ONE, 7 * ONE));
        send_cell(make_cell(CMD_C2P, 2 * ONE, ONE, 5 * ONE, 7 * ONE));
        send_cell(make_cell(CMD_C2P, ONE, '0, WMAX, 32'sd1));
        random_phase(160, 25);
        drain();

        // MHD back on, opposite gamma extremes, sender idles more.
        write_cfg(CFG_MHD, 31'd1);
        write_cfg(CFG_GM1, 31'd1);
        write_cfg(CFG_IGM1, 31'h7fff_ffff);
        random_phase(160, 51);
        drain();

        // Typical gas settings, no idling.
        write_cfg(CFG_GM1, GAMMA_W'($urandom_range(1 << 17, 1)));
        write_cfg(CFG_IGM1, GAMMA_W'($urandom_range(1 << 18, 1)));
        random_phase(160, 0);
        drain();

        $display("covered %0d items (%0d forward, %0d inverse), %0d results checked",
                 accepted_items, sb.cmd_seen[0], sb.cmd_seen[1], sb.checked);
        $display("status counts: ok %0d, bad density %0d, saturated %0d; %0d mismatches",
                 sb.status_seen[ST_OK], sb.status_seen[ST_BADRHO],
                 sb.status_seen[ST_SAT], sb.mismatches);
        if (sb.mismatches == 0 && sb.owed_cells.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
